FILE: rtl/ega_p2r_pkg.sv
// ----------------------------------------------------------------------------
// ega_p2r_pkg
// Shared constants and color tables for the EGA planar to ARGB expander.
// ----------------------------------------------------------------------------
package ega_p2r_pkg;

  // group geometry
  localparam int unsigned PIXELS_PER_GROUP = 8;
  localparam int unsigned PIX_CNT_W        = $clog2(PIXELS_PER_GROUP);
  localparam logic [PIX_CNT_W-1:0] LAST_PIXEL = PIX_CNT_W'(PIXELS_PER_GROUP - 1);

  // field widths
  localparam int unsigned PLANE_W = 8;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned BG_W    = 8;
  localparam int unsigned ARGB_W  = 32;
  localparam int unsigned PAL_W   = 6;

  // color word for a background pixel
  localparam logic [ARGB_W-1:0] ARGB_TRANSPARENT = '0;

  // default attribute map: color index to palette entry
  localparam logic [PAL_W-1:0] ATTR_MAP16 [16] = '{
    6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd20, 6'd7,
    6'd56, 6'd57, 6'd58, 6'd59, 6'd60, 6'd61, 6'd62, 6'd63
  };

  // 64-entry EGA palette, opaque ARGB
  localparam logic [ARGB_W-1:0] EGA_RGB64 [64] = '{
    32'hFF000000, 32'hFFAA0000, 32'hFF00AA00, 32'hFFAAAA00,
    32'hFF0000AA, 32'hFFAA00AA, 32'hFF00AAAA, 32'hFFAAAAAA,
    32'hFF550000, 32'hFFFF0000, 32'hFF55AA00, 32'hFFFFAA00,
    32'hFF5500AA, 32'hFFFF00AA, 32'hFF55AAAA, 32'hFFFFAAAA,
    32'hFF005500, 32'hFFAA5500, 32'hFF00FF00, 32'hFFAAFF00,
    32'hFF0055AA, 32'hFFAA55AA, 32'hFF00FFAA, 32'hFFAAFFAA,
    32'hFF555500, 32'hFFFF5500, 32'hFF55FF00, 32'hFFFFFF00,
    32'hFF5555AA, 32'hFFFF55AA, 32'hFF55FFAA, 32'hFFFFFFAA,
    32'hFF000055, 32'hFFAA0055, 32'hFF00AA55, 32'hFFAAAA55,
    32'hFF0000FF, 32'hFFAA00FF, 32'hFF00AAFF, 32'hFFAAAAFF,
    32'hFF550055, 32'hFFFF0055, 32'hFF55AA55, 32'hFFFFAA55,
    32'hFF5500FF, 32'hFFFF00FF, 32'hFF55AAFF, 32'hFFFFAAFF,
    32'hFF005555, 32'hFFAA5555, 32'hFF00FF55, 32'hFFAAFF55,
    32'hFF0055FF, 32'hFFAA55FF, 32'hFF00FFFF, 32'hFFAAFFFF,
    32'hFF555555, 32'hFFFF5555, 32'hFF55FF55, 32'hFFFFFF55,
    32'hFF5555FF, 32'hFFFF55FF, 32'hFF55FFFF, 32'hFFFFFFFF
  };

  // color index through attribute map and palette
  function automatic logic [ARGB_W-1:0] index_to_argb(input logic [INDEX_W-1:0] idx);
    return EGA_RGB64[ATTR_MAP16[idx]];
  endfunction

endpackage

FILE: rtl/ega_planar_to_rgba_expander.sv
// ----------------------------------------------------------------------------
// ega_planar_to_rgba_expander
// Expands one group of four EGA bit-plane bytes into eight ARGB pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per group of
//   eight pixels: four plane bytes plus an end-of-image mark.
//   Output channel (out_valid/out_ready) carries one pixel per transaction,
//   leftmost pixel (bit 7) first; the eighth pixel has out_last_of_group set
//   and, for a group marked end of image, out_image_done too.
//   cfg_wr_en/cfg_wr_data set the background color index (reset 0); write it
//   only while the block is empty. Indexes above 15 never match.
// Timing:
//   The first pixel of a group passes through the group register and then
//   the output register. The group register is drained by a pixel counter,
//   one pixel per cycle while out_ready allows; the next group is taken in
//   the cycle its predecessor's eighth pixel moves to the output register,
//   so groups follow one another with no gaps.
// Reset and stall:
//   Reset empties the group and output registers and clears the background
//   index. While out_ready is low with a pixel on the outputs, the output
//   register and pixel counter hold and in_ready drops once a group is waiting.
// ----------------------------------------------------------------------------
module ega_planar_to_rgba_expander
  import ega_p2r_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [BG_W-1:0]    cfg_wr_data,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PLANE_W-1:0] in_plane0_byte,
  input  logic [PLANE_W-1:0] in_plane1_byte,
  input  logic [PLANE_W-1:0] in_plane2_byte,
  input  logic [PLANE_W-1:0] in_plane3_byte,
  input  logic               in_end_of_image,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ARGB_W-1:0]  out_pixel_argb,
  output logic               out_last_of_group,
  output logic               out_image_done
);

  // registers
  logic [BG_W-1:0]      bg_index_r;
  logic                 grp_valid_r, grp_valid_nxt;
  logic [PLANE_W-1:0]   p0_r, p1_r, p2_r, p3_r;
  logic                 eoi_r;
  logic [PIX_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ARGB_W-1:0]    argb_r;
  logic                 last_r;
  logic                 done_r;

  // datapath signals
  logic                 out_adv;
  logic                 pix_issue;
  logic                 in_take;
  logic [PIX_CNT_W-1:0] bit_sel;
  logic [INDEX_W-1:0]   pix_idx;
  logic                 is_bg;
  logic [ARGB_W-1:0]    pix_argb;
  logic                 pix_last;

  // background index register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_index_r <= '0;
    end else if (cfg_wr_en) begin
      bg_index_r <= cfg_wr_data;
    end
  end

  // handshake control
  assign out_adv   = !out_valid_r || out_ready;
  assign pix_issue = grp_valid_r && out_adv;
  assign pix_last  = (cnt_r == LAST_PIXEL);
  assign in_ready  = !grp_valid_r || (pix_issue && pix_last);
  assign in_take   = in_valid && in_ready;

  always_comb begin
    grp_valid_nxt = grp_valid_r;
    cnt_nxt       = cnt_r;
    if (in_take) begin
      grp_valid_nxt = 1'b1;
      cnt_nxt       = '0;
    end else if (pix_issue) begin
      grp_valid_nxt = !pix_last;
      cnt_nxt       = cnt_r + PIX_CNT_W'(1);
    end
    out_valid_nxt = out_adv ? grp_valid_r : out_valid_r;
  end

  // pixel index from the planes, leftmost bit first
  assign bit_sel  = LAST_PIXEL - cnt_r;
  assign pix_idx  = {p3_r[bit_sel], p2_r[bit_sel], p1_r[bit_sel], p0_r[bit_sel]};
  assign is_bg    = ({{(BG_W-INDEX_W){1'b0}}, pix_idx} == bg_index_r);
  assign pix_argb = is_bg ? ARGB_TRANSPARENT : index_to_argb(pix_idx);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_valid_r <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      grp_valid_r <= grp_valid_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // group payload register
  always_ff @(posedge clk) begin
    if (in_take) begin
      p0_r  <= in_plane0_byte;
      p1_r  <= in_plane1_byte;
      p2_r  <= in_plane2_byte;
      p3_r  <= in_plane3_byte;
      eoi_r <= in_end_of_image;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (pix_issue) begin
      argb_r <= pix_argb;
      last_r <= pix_last;
      done_r <= pix_last && eoi_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_argb    = argb_r;
  assign out_last_of_group = last_r;
  assign out_image_done    = done_r;

`ifndef SYNTHESIS
  // image done only on the last pixel of a group
  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> last_r)
    else $error("image_done without last_of_group");

  // an accepted group starts at pixel zero
  a_group_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (grp_valid_r && cnt_r == '0))
    else $error("new group not loaded at pixel zero");

  // the eighth pixel issued shows up flagged as last
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (pix_issue && pix_last) |=> (out_valid_r && last_r))
    else $error("last pixel of group not flagged");

  // any non-background pixel is fully opaque
  a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && argb_r != ARGB_TRANSPARENT) |-> (argb_r[ARGB_W-1 -: 8] == 8'hFF))
    else $error("visible pixel not opaque");
`endif

endmodule
